// ===== rtl/deq_pkg.sv =====
// Shared command and status codes for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  // Command codes carried on the input channel
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_READ_INDEX = 3'd2,
    CMD_READ_FRONT = 3'd3,
    CMD_READ_BACK  = 3'd4
  } cmd_t;

  // Status codes carried on the result channel
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ERR  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Per-command outcome handed from the pointer control to the result stage
  typedef struct packed {
    logic    read_ok;
    status_t status;
  } res_info_t;

  localparam int CMD_BITS   = 3;
  localparam int DATA_BITS  = 32;
  localparam int POS_BITS   = 4;
  localparam int COUNT_BITS = 5;

endpackage

// ===== rtl/deq_if.sv =====
// Valid/ready channel interfaces for commands and results of the queue.
`timescale 1ns / 1ps

interface deq_in_if;
  import deq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [CMD_BITS-1:0]         command;
  logic signed [DATA_BITS-1:0] push_value;
  logic [POS_BITS-1:0]         position;

  modport source (output valid, command, push_value, position, input ready);
  modport sink   (input valid, command, push_value, position, output ready);
endinterface

interface deq_out_if;
  import deq_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] read_data;
  logic [1:0]                  status;
  logic [COUNT_BITS-1:0]       entry_count;
  logic                        is_empty;

  modport source (output valid, read_data, status, entry_count, is_empty, input ready);
  modport sink   (input valid, read_data, status, entry_count, is_empty, output ready);
endinterface

// ===== rtl/deq_mem.sv =====
// Single-port entry store with registered read data.
`timescale 1ns / 1ps

module deq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic             rd_en,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wr_data;
    end
  end

  // Read the addressed entry, hold the data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/deq_ctrl.sv =====
// Head pointer and entry count, ring address generation and status decode.
`timescale 1ns / 1ps

module deq_ctrl #(
  parameter int CAPACITY = 16,
  parameter int PW       = 4,
  parameter int CW       = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc,
  input  logic [2:0]             command,
  input  logic [3:0]             position,
  output logic                   mem_we,
  output logic                   mem_re,
  output logic [PW-1:0]          mem_addr,
  output deq_pkg::res_info_t     info,
  output logic [CW-1:0]          count_nxt,
  output logic [CW-1:0]          cur_count
);
  import deq_pkg::*;

  localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

  logic [PW-1:0] head_r;
  logic [PW-1:0] head_nxt;
  logic [CW-1:0] count_r;
  logic [PW-1:0] offset;
  logic [PW:0]   slot_sum;
  logic          is_full;
  logic          is_empty;
  logic          in_range;
  logic          front_push;

  assign is_full  = (count_r >= CW'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign in_range = (CMPW'(position) < CMPW'(count_r));

  // Decode the command into a store access and pointer updates
  always_comb begin
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    offset       = '0;
    front_push   = 1'b0;
    count_nxt    = count_r;
    info.read_ok = 1'b0;
    info.status  = ST_OK;
    unique case (cmd_t'(command))
      CMD_PUSH_FRONT: begin
        offset = PW'(CAPACITY - 1);
        if (is_full) begin
          info.status = ST_FULL;
        end else begin
          mem_we     = 1'b1;
          front_push = 1'b1;
          count_nxt  = count_r + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        offset = PW'(count_r);
        if (is_full) begin
          info.status = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_READ_INDEX: begin
        offset = PW'(position);
        if (in_range) begin
          mem_re       = 1'b1;
          info.read_ok = 1'b1;
        end else begin
          info.status = ST_ERR;
        end
      end
      CMD_READ_FRONT: begin
        if (is_empty) begin
          info.status = ST_ERR;
        end else begin
          mem_re       = 1'b1;
          info.read_ok = 1'b1;
        end
      end
      CMD_READ_BACK: begin
        offset = PW'(count_r - 1'b1);
        if (is_empty) begin
          info.status = ST_ERR;
        end else begin
          mem_re       = 1'b1;
          info.read_ok = 1'b1;
        end
      end
      default: begin
        info.status = ST_ERR;
      end
    endcase
  end

  // Wrap head plus offset around the ring with one compare and subtract
  assign slot_sum = (PW+1)'(head_r) + (PW+1)'(offset);
  assign mem_addr = (slot_sum >= (PW+1)'(CAPACITY)) ?
                    PW'(slot_sum - (PW+1)'(CAPACITY)) : PW'(slot_sum);

  // Move the head back one slot on an accepted front push
  assign head_nxt = front_push ? mem_addr : head_r;

  // Advance the pointers on each command transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (acc) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  assign cur_count = count_r;

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: control, entry store and result stages.
`timescale 1ns / 1ps

// Double-ended queue of CAPACITY words of WORD_BITS in a ring store. Commands
// push at the front or back, or read by index, front or back; each command
// gives exactly one result with the read word (sign-extended to 32 bits, zero
// on pushes and errors), a status, the entry count after the command and an
// empty flag. The block takes one command per cycle while results drain. The
// store read and the command outcome register at the command transfer, and
// the output register loads from them once it is free, so each result passes
// through both registers before it is presented. When the result side stalls,
// one more command is taken behind the waiting result and then the input is
// held off. The store has no reset and needs no clearing pass: only entries
// below the count are read.
module double_ended_queue #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  deq_in_if.sink   in_if,
  deq_out_if.source out_if
);
  import deq_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                 in_acc;
  logic                 mem_we;
  logic                 mem_re;
  logic [PW-1:0]        mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;
  res_info_t            info;
  logic [CW-1:0]        count_nxt;
  logic [CW-1:0]        cur_count;

  logic                  s1_valid_r;
  res_info_t             s1_info_r;
  logic [COUNT_BITS-1:0] s1_count_r;
  logic                  s1_empty_r;
  logic                  s1_adv;

  logic                        out_valid_r;
  logic signed [DATA_BITS-1:0] out_data_r;
  status_t                     out_status_r;
  logic [COUNT_BITS-1:0]       out_count_r;
  logic                        out_empty_r;
  logic signed [DATA_BITS-1:0] s1_data;

  assign in_acc      = in_if.valid & in_if.ready;
  assign s1_adv      = s1_valid_r & (~out_valid_r | out_if.ready);
  assign in_if.ready = ~s1_valid_r | s1_adv;

  // Keep the low WORD_BITS of the sign-extended push word
  assign mem_wdata = WORD_BITS'(in_if.push_value);

  deq_ctrl #(
    .CAPACITY (CAPACITY),
    .PW       (PW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .command   (in_if.command),
    .position  (in_if.position),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .info      (info),
    .count_nxt (count_nxt),
    .cur_count (cur_count)
  );

  deq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (WORD_BITS),
    .AW    (PW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we & in_acc),
    .rd_en   (mem_re & in_acc),
    .addr    (mem_addr),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

  // Hold the command outcome while the store read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_info_r  <= info;
      s1_count_r <= COUNT_BITS'(count_nxt);
      s1_empty_r <= (count_nxt == '0);
    end
  end

  // Sign-extend the stored word, drop it on pushes and errors
  assign s1_data = s1_info_r.read_ok ? DATA_BITS'($signed(mem_rdata)) : '0;

  // Output register: load on advance, drop on result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r   <= s1_data;
      out_status_r <= s1_info_r.status;
      out_count_r  <= s1_count_r;
      out_empty_r  <= s1_empty_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.read_data   = out_data_r;
  assign out_if.status      = out_status_r;
  assign out_if.entry_count = out_count_r;
  assign out_if.is_empty    = out_empty_r;

  // Count never passes the capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    cur_count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // Count moves only after a command transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(cur_count))
    else $error("entry count changed without a command");

  // Errors and refused pushes carry zero data
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_data_r == '0))
    else $error("nonzero data on error result");

  // An empty flag implies a zero count field
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_count_r == '0))
    else $error("empty flag with nonzero count");

endmodule

// ===== sim/double_ended_queue_tb.sv =====
// Self-checking testbench for the double-ended queue: directed table, random commands, stalls.
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int DEPTH          = 16;
  localparam int RANDOM_ITEMS   = 600;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 60;
  localparam int HOLD_AFTER     = 120;
  localparam int PLAN_ROWS      = 27;

  // Command codes the block does not define; it must answer them with an error
  localparam logic [CMD_BITS-1:0] CMD_RESERVED_LO = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_RESERVED_HI = 3'd7;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] read_data;
    status_t                     status;
    logic [COUNT_BITS-1:0]       entry_count;
    logic                        is_empty;
  } deq_result_t;

  typedef struct {
    logic [CMD_BITS-1:0]         command;
    logic signed [DATA_BITS-1:0] push_value;
    logic [POS_BITS-1:0]         position;
    bit                          preset;
    deq_result_t                 want;
  } plan_row_t;

  typedef struct {
    bit          preset;
    deq_result_t want;
  } preset_tag_t;

  logic clk = 1'b0;
  logic rst_n;

  deq_in_if  cmd_ch ();
  deq_out_if res_ch ();

  double_ended_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_ch),
    .out_if (res_ch)
  );

  always #10 clk = ~clk;

  // Mirror of the ring store, front index and fill level
  logic signed [DATA_BITS-1:0] mirror_entries [DEPTH];
  logic [POS_BITS-1:0]         mirror_head  = '0;
  logic [COUNT_BITS-1:0]       mirror_count = '0;

  deq_result_t pending_results [$];
  preset_tag_t preset_results [$];
  plan_row_t   plan [PLAN_ROWS];

  int mismatches   = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int burst_left   = 0;

  // Work out the result of one command and advance the mirror state
  function automatic deq_result_t apply_command(input logic [CMD_BITS-1:0] code,
                                                input logic signed [DATA_BITS-1:0] word,
                                                input logic [POS_BITS-1:0] index);
    deq_result_t r;
    logic [POS_BITS-1:0] slot;
    r.read_data = '0;
    r.status    = ST_OK;
    case (code)
      CMD_PUSH_FRONT: begin
        if (mirror_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_head = mirror_head - 1'b1;
          mirror_entries[mirror_head] = word;
          mirror_count++;
        end
      end
      CMD_PUSH_BACK: begin
        if (mirror_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot = mirror_head + mirror_count[POS_BITS-1:0];
          mirror_entries[slot] = word;
          mirror_count++;
        end
      end
      CMD_READ_INDEX: begin
        if ({1'b0, index} >= mirror_count) begin
          r.status = ST_ERR;
        end else begin
          slot = mirror_head + index;
          r.read_data = mirror_entries[slot];
        end
      end
      CMD_READ_FRONT: begin
        if (mirror_count == 0) r.status = ST_ERR;
        else r.read_data = mirror_entries[mirror_head];
      end
      CMD_READ_BACK: begin
        if (mirror_count == 0) begin
          r.status = ST_ERR;
        end else begin
          slot = mirror_head + mirror_count[POS_BITS-1:0] - 1'b1;
          r.read_data = mirror_entries[slot];
        end
      end
      default: r.status = ST_ERR;
    endcase
    r.entry_count = mirror_count;
    r.is_empty    = (mirror_count == 0);
    return r;
  endfunction

  // Predict on each command transfer, then check each result transfer
  always @(posedge clk) begin
    deq_result_t want;
    preset_tag_t tag;
    logic in_xfer, out_xfer;
    in_xfer  = rst_n && cmd_ch.valid && cmd_ch.ready;
    out_xfer = rst_n && res_ch.valid && res_ch.ready;
    if (in_xfer) begin
      want = apply_command(cmd_ch.command, cmd_ch.push_value, cmd_ch.position);
      if (preset_results.size() != 0) begin
        tag = preset_results.pop_front();
        if (tag.preset) want = tag.want;
      end
      pending_results.insert(pending_results.size(), want);
    end
    if (out_xfer) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, res_ch.read_data);
          mismatches++;
        end
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          mismatches++;
        end
        if (res_ch.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, res_ch.entry_count);
          mismatches++;
        end
        if (res_ch.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, res_ch.is_empty);
          mismatches++;
        end
      end
    end
    if (!rst_n || in_xfer || out_xfer) stall_cycles = 0;
    else stall_cycles++;
  end

  // End the run when neither channel moves for too long
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Receiver: stall in stretches of random style, with one long hold-off
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit held;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    mode      = 0;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (!held && results_seen >= HOLD_AFTER) begin
        // hold off long enough for the block to fill and stall its input
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        case (mode)
          0:       res_ch.ready <= 1'b1;
          1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
          default: res_ch.ready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // Offer one command, with a random gap before each burst; return at a falling edge
  task automatic offer(input logic [CMD_BITS-1:0] code, input logic signed [DATA_BITS-1:0] word,
                       input logic [POS_BITS-1:0] index, input bit preset,
                       input deq_result_t want);
    int gap;
    preset_tag_t tag;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    tag.preset = preset;
    tag.want   = want;
    preset_results.insert(preset_results.size(), tag);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= code;
    cmd_ch.push_value <= word;
    cmd_ch.position   <= index;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    int pick;
    logic [CMD_BITS-1:0] code;

    // Directed rows: empty reads, extremes, fill to capacity, refused pushes
    plan = '{
      '{CMD_READ_FRONT,  32'h00000000, 4'd0,  1'b1, '{32'h0, ST_ERR, 5'd0, 1'b1}},
      '{CMD_READ_BACK,   32'hFFFFFFFF, 4'd15, 1'b1, '{32'h0, ST_ERR, 5'd0, 1'b1}},
      '{CMD_READ_INDEX,  32'h00000000, 4'd0,  1'b1, '{32'h0, ST_ERR, 5'd0, 1'b1}},
      '{CMD_RESERVED_LO, 32'h7FFFFFFF, 4'd15, 1'b1, '{32'h0, ST_ERR, 5'd0, 1'b1}},
      '{CMD_PUSH_BACK,   32'h7FFFFFFF, 4'd0,  1'b1, '{32'h0, ST_OK,  5'd1, 1'b0}},
      '{CMD_PUSH_FRONT,  32'h80000000, 4'd0,  1'b1, '{32'h0, ST_OK,  5'd2, 1'b0}},
      '{CMD_READ_FRONT,  32'h00000000, 4'd0,  1'b1, '{32'h80000000, ST_OK, 5'd2, 1'b0}},
      '{CMD_READ_BACK,   32'h00000000, 4'd0,  1'b1, '{32'h7FFFFFFF, ST_OK, 5'd2, 1'b0}},
      '{CMD_READ_INDEX,  32'h00000000, 4'd1,  1'b1, '{32'h7FFFFFFF, ST_OK, 5'd2, 1'b0}},
      '{CMD_READ_INDEX,  32'h00000000, 4'd2,  1'b1, '{32'h0, ST_ERR, 5'd2, 1'b0}},
      '{CMD_PUSH_FRONT,  32'hFFFFFFFF, 4'd0,  1'b0, '0},
      '{CMD_PUSH_BACK,   32'h00000000, 4'd0,  1'b0, '0},
      '{CMD_PUSH_FRONT,  32'h00000001, 4'd0,  1'b0, '0},
      '{CMD_PUSH_BACK,   32'h55555555, 4'd0,  1'b0, '0},
      '{CMD_PUSH_FRONT,  32'hAAAAAAAA, 4'd0,  1'b0, '0},
      '{CMD_PUSH_BACK,   32'h80000001, 4'd0,  1'b0, '0},
      '{CMD_PUSH_FRONT,  32'h7FFFFFFE, 4'd0,  1'b0, '0},
      '{CMD_PUSH_BACK,   32'h0F0F0F0F, 4'd0,  1'b0, '0},
      '{CMD_PUSH_FRONT,  32'hF0F0F0F0, 4'd0,  1'b0, '0},
      '{CMD_PUSH_BACK,   32'h00FF00FF, 4'd0,  1'b0, '0},
      '{CMD_PUSH_FRONT,  32'hFF00FF00, 4'd0,  1'b0, '0},
      '{CMD_PUSH_BACK,   32'h12345678, 4'd0,  1'b0, '0},
      '{CMD_PUSH_FRONT,  32'hDEADBEEF, 4'd0,  1'b0, '0},
      '{CMD_PUSH_BACK,   32'hC0FFEE00, 4'd0,  1'b0, '0},
      '{CMD_PUSH_BACK,   32'h12345678, 4'd0,  1'b1, '{32'h0, ST_FULL, 5'd16, 1'b0}},
      '{CMD_PUSH_FRONT,  32'hFFFFFFFF, 4'd0,  1'b1, '{32'h0, ST_FULL, 5'd16, 1'b0}},
      '{CMD_READ_INDEX,  32'h00000000, 4'd15, 1'b0, '0}
    };

    cmd_ch.valid      = 1'b0;
    cmd_ch.command    = CMD_READ_FRONT;
    cmd_ch.push_value = '0;
    cmd_ch.position   = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i])
      offer(plan[i].command, plan[i].push_value, plan[i].position, plan[i].preset, plan[i].want);

    // Nothing removes entries, so the store stays full from here on:
    // mostly reads across every slot, with refused pushes and undefined codes mixed in
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)      code = CMD_PUSH_FRONT;
      else if (pick < 20) code = CMD_PUSH_BACK;
      else if (pick < 60) code = CMD_READ_INDEX;
      else if (pick < 75) code = CMD_READ_FRONT;
      else if (pick < 90) code = CMD_READ_BACK;
      else                code = CMD_BITS'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
      offer(code, $urandom(), POS_BITS'($urandom_range(0, DEPTH - 1)), 1'b0, '0);
    end
    cmd_ch.valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
